>>> rtl/lkv_pkg.sv
// Shared widths, operation codes and bundle types for the LRU key-value cache.
`timescale 1ns / 1ps

package lkv_pkg;

    // Default geometry
    localparam int DEF_ENTRIES    = 16;
    localparam int DEF_KEY_BITS   = 64;
    localparam int DEF_VALUE_BITS = 32;

    // Stream field widths
    localparam int FUNC_W    = 2;
    localparam int IN_KEY_W  = 64;
    localparam int IN_VAL_W  = 32;
    localparam int OUT_VAL_W = 32;
    localparam int OUT_KEY_W = 64;
    localparam int OCC_W     = 5;
    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 104;

    // Capacity register
    localparam int              CAP_W     = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_GET = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_PUT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DEL = 2'd2;

    // Write enables into the entry store
    typedef struct packed {
        logic key_we;
        logic val_we;
        logic rank_we;
    } lkv_wr_t;

    // One result, packed with hit in the lowest bit
    typedef struct packed {
        logic [OCC_W-1:0]     occupancy;
        logic [OUT_KEY_W-1:0] evicted_key;
        logic                 evicted;
        logic [OUT_VAL_W-1:0] read_value;
        logic                 hit;
    } lkv_result_t;

endpackage

>>> rtl/lkv_store.sv
// Entry store: key, value and recency-rank memories with registered reads.
`timescale 1ns / 1ps

module lkv_store
    import lkv_pkg::*;
#(
    parameter int   ENTRIES    = DEF_ENTRIES,
    parameter int   KEY_BITS   = DEF_KEY_BITS,
    parameter int   VALUE_BITS = DEF_VALUE_BITS,
    localparam int  IDX_W      = $clog2(ENTRIES)
)
(
    input  logic                  clk,
    input  logic [IDX_W-1:0]      rd_addr,
    input  lkv_wr_t               wr,
    input  logic [IDX_W-1:0]      wr_addr,
    input  logic [KEY_BITS-1:0]   wr_key,
    input  logic [VALUE_BITS-1:0] wr_val,
    input  logic [IDX_W-1:0]      wr_rank,
    output logic [KEY_BITS-1:0]   rd_key,
    output logic [VALUE_BITS-1:0] rd_val,
    output logic [IDX_W-1:0]      rd_rank
);

    logic [KEY_BITS-1:0]   key_mem  [ENTRIES];
    logic [VALUE_BITS-1:0] val_mem  [ENTRIES];
    logic [IDX_W-1:0]      rank_mem [ENTRIES];

    logic [KEY_BITS-1:0]   rd_key_reg;
    logic [VALUE_BITS-1:0] rd_val_reg;
    logic [IDX_W-1:0]      rd_rank_reg;

    // Write one port, read one port, read data registered
    always_ff @(posedge clk)
    begin
        if (wr.key_we)
        begin
            key_mem[wr_addr] <= wr_key;
        end
        if (wr.val_we)
        begin
            val_mem[wr_addr] <= wr_val;
        end
        if (wr.rank_we)
        begin
            rank_mem[wr_addr] <= wr_rank;
        end
        rd_key_reg  <= key_mem[rd_addr];
        rd_val_reg  <= val_mem[rd_addr];
        rd_rank_reg <= rank_mem[rd_addr];
    end

    assign rd_key  = rd_key_reg;
    assign rd_val  = rd_val_reg;
    assign rd_rank = rd_rank_reg;

endmodule

>>> rtl/lkv_engine.sv
// Sequencer that sweeps the entry store through one shared key comparator.
`timescale 1ns / 1ps

module lkv_engine
    import lkv_pkg::*;
#(
    parameter int ENTRIES    = DEF_ENTRIES,
    parameter int KEY_BITS   = DEF_KEY_BITS,
    parameter int VALUE_BITS = DEF_VALUE_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_start,
    input  logic [FUNC_W-1:0]    in_func,
    input  logic [IN_KEY_W-1:0]  in_key,
    input  logic [IN_VAL_W-1:0]  in_value,
    input  logic [CAP_W-1:0]     cap,
    output logic                 in_ready,
    output logic                 res_valid,
    input  logic                 res_ready,
    output lkv_result_t          res
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DECIDE,
        ST_UPDATE,
        ST_COMMIT,
        ST_DONE
    } state_t;

    // Control state
    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [ENTRIES-1:0]   valid_reg, valid_next;
    logic [CNT_W-1:0]     count_reg, count_next;

    // Request and scan payload
    logic [FUNC_W-1:0]     func_reg, func_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic                  hit_reg, hit_next;
    logic [IDX_W-1:0]      slot_reg, slot_next;
    logic [IDX_W-1:0]      rank_s_reg, rank_s_next;
    logic [VALUE_BITS-1:0] rd_val_reg, rd_val_next;
    logic                  old_found_reg, old_found_next;
    logic [IDX_W-1:0]      old_idx_reg, old_idx_next;
    logic [IDX_W-1:0]      old_rank_reg, old_rank_next;
    logic [KEY_BITS-1:0]   old_key_reg, old_key_next;
    logic                  free_found_reg, free_found_next;
    logic [IDX_W-1:0]      free_idx_reg, free_idx_next;
    logic                  evict_reg, evict_next;
    logic                  mode_inc_reg, mode_inc_next;
    logic                  mode_dec_reg, mode_dec_next;
    logic                  tgt_en_reg, tgt_en_next;
    logic [IDX_W-1:0]      tgt_reg, tgt_next;
    logic [CNT_W-1:0]      thr_reg, thr_next;
    lkv_result_t           res_reg, res_next;

    // Store interface
    logic [IDX_W-1:0]      rd_addr;
    lkv_wr_t               wr;
    logic [IDX_W-1:0]      wr_addr;
    logic [IDX_W-1:0]      wr_rank;
    logic [KEY_BITS-1:0]   rd_key;
    logic [VALUE_BITS-1:0] rd_val;
    logic [IDX_W-1:0]      rd_rank;

    // Helpers
    logic [CNT_W-1:0]      cnt_dec;
    logic [IDX_W-1:0]      proc_idx;
    logic                  proc_valid;
    logic                  cnt_last;
    logic                  key_eq;
    logic [CNT_W-1:0]      rank_wide;
    logic [CMP_W-1:0]      cap_wide;
    logic [CMP_W-1:0]      cap_eff;
    logic                  full;
    logic [IN_VAL_W+VALUE_BITS-1:0]  in_val_ext;
    logic [VALUE_BITS+OUT_VAL_W-1:0] rd_val_ext;
    logic [KEY_BITS+OUT_KEY_W-1:0]   old_key_ext;
    logic [CNT_W+OCC_W-1:0]          occ_ext;

    lkv_store #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_store (
        .clk     (clk),
        .rd_addr (rd_addr),
        .wr      (wr),
        .wr_addr (wr_addr),
        .wr_key  (key_reg),
        .wr_val  (val_reg),
        .wr_rank (wr_rank),
        .rd_key  (rd_key),
        .rd_val  (rd_val),
        .rd_rank (rd_rank)
    );

    // Sweep position: read slot cnt, process slot cnt-1
    assign cnt_dec    = cnt_reg - CNT_W'(1);
    assign proc_idx   = cnt_dec[IDX_W-1:0];
    assign proc_valid = valid_reg[proc_idx];
    assign cnt_last   = (cnt_reg == CNT_W'(ENTRIES));
    assign rd_addr    = (cnt_reg < CNT_W'(ENTRIES)) ? cnt_reg[IDX_W-1:0] : '0;

    // Shared key comparator
    assign key_eq    = (rd_key == key_reg);
    assign rank_wide = CNT_W'(rd_rank);

    // Clamp capacity to 1..ENTRIES
    assign cap_wide = CMP_W'(cap);
    always_comb
    begin
        if (cap_wide == '0)
        begin
            cap_eff = CMP_W'(1);
        end
        else if (cap_wide > CMP_W'(ENTRIES))
        begin
            cap_eff = CMP_W'(ENTRIES);
        end
        else
        begin
            cap_eff = cap_wide;
        end
    end
    assign full = (CMP_W'(count_reg) >= cap_eff);

    // Width adaption of fields
    assign in_val_ext  = {{VALUE_BITS{1'b0}}, in_value};
    assign rd_val_ext  = {{OUT_VAL_W{1'b0}}, rd_val_reg};
    assign old_key_ext = {{OUT_KEY_W{1'b0}}, old_key_reg};
    assign occ_ext     = {{OCC_W{1'b0}}, count_next};

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        valid_next      = valid_reg;
        count_next      = count_reg;
        func_next       = func_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        hit_next        = hit_reg;
        slot_next       = slot_reg;
        rank_s_next     = rank_s_reg;
        rd_val_next     = rd_val_reg;
        old_found_next  = old_found_reg;
        old_idx_next    = old_idx_reg;
        old_rank_next   = old_rank_reg;
        old_key_next    = old_key_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        evict_next      = evict_reg;
        mode_inc_next   = mode_inc_reg;
        mode_dec_next   = mode_dec_reg;
        tgt_en_next     = tgt_en_reg;
        tgt_next        = tgt_reg;
        thr_next        = thr_reg;
        res_next        = res_reg;
        wr              = '0;
        wr_addr         = proc_idx;
        wr_rank         = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                // Take the request and arm the scan
                if (in_start)
                begin
                    func_next       = in_func;
                    key_next        = in_key[KEY_BITS-1:0];
                    val_next        = in_val_ext[VALUE_BITS-1:0];
                    hit_next        = 1'b0;
                    rd_val_next     = '0;
                    old_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    cnt_next        = '0;
                    state_next      = ST_SEARCH;
                end
            end

            ST_SEARCH:
            begin
                // Look for the key, the oldest entry and the first free slot
                if (cnt_reg != '0)
                begin
                    if (proc_valid && key_eq)
                    begin
                        hit_next    = 1'b1;
                        slot_next   = proc_idx;
                        rank_s_next = rd_rank;
                        rd_val_next = rd_val;
                    end
                    if (proc_valid && (!old_found_reg || rd_rank > old_rank_reg))
                    begin
                        old_found_next = 1'b1;
                        old_idx_next   = proc_idx;
                        old_rank_next  = rd_rank;
                        old_key_next   = rd_key;
                    end
                    if (!proc_valid && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = proc_idx;
                    end
                end
                if (cnt_last)
                begin
                    state_next = ST_DECIDE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end

            ST_DECIDE:
            begin
                // Choose how the recency ranks move
                cnt_next      = '0;
                evict_next    = 1'b0;
                mode_inc_next = 1'b0;
                mode_dec_next = 1'b0;
                tgt_en_next   = 1'b0;
                case (func_reg)
                    FUNC_GET:
                    begin
                        if (hit_reg)
                        begin
                            mode_inc_next = 1'b1;
                            tgt_en_next   = 1'b1;
                            tgt_next      = slot_reg;
                            thr_next      = CNT_W'(rank_s_reg);
                        end
                    end
                    FUNC_PUT:
                    begin
                        mode_inc_next = 1'b1;
                        tgt_en_next   = 1'b1;
                        if (hit_reg)
                        begin
                            tgt_next = slot_reg;
                            thr_next = CNT_W'(rank_s_reg);
                        end
                        else if (full)
                        begin
                            evict_next = 1'b1;
                            thr_next   = CNT_W'(old_rank_reg);
                            if (free_found_reg && free_idx_reg < old_idx_reg)
                            begin
                                tgt_next = free_idx_reg;
                            end
                            else
                            begin
                                tgt_next = old_idx_reg;
                            end
                        end
                        else
                        begin
                            thr_next = count_reg;
                            tgt_next = free_idx_reg;
                        end
                    end
                    FUNC_DEL:
                    begin
                        if (hit_reg)
                        begin
                            mode_dec_next = 1'b1;
                            thr_next      = CNT_W'(rank_s_reg);
                        end
                    end
                    default:
                    begin
                    end
                endcase
                if (((func_reg == FUNC_GET) || (func_reg == FUNC_DEL)) && hit_reg
                    || (func_reg == FUNC_PUT))
                begin
                    state_next = ST_UPDATE;
                end
                else
                begin
                    state_next = ST_COMMIT;
                end
            end

            ST_UPDATE:
            begin
                // Rewrite each rank behind the read
                if (cnt_reg != '0)
                begin
                    if (tgt_en_reg && proc_idx == tgt_reg)
                    begin
                        wr.rank_we = 1'b1;
                        wr_rank    = '0;
                    end
                    else if (proc_valid && mode_inc_reg && rank_wide < thr_reg)
                    begin
                        wr.rank_we = 1'b1;
                        wr_rank    = rd_rank + IDX_W'(1);
                    end
                    else if (proc_valid && mode_dec_reg && rank_wide > thr_reg)
                    begin
                        wr.rank_we = 1'b1;
                        wr_rank    = rd_rank - IDX_W'(1);
                    end
                end
                if (cnt_last)
                begin
                    state_next = ST_COMMIT;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end

            ST_COMMIT:
            begin
                // Apply key, value and valid changes and form the result
                case (func_reg)
                    FUNC_PUT:
                    begin
                        wr.val_we = 1'b1;
                        if (hit_reg)
                        begin
                            wr_addr = slot_reg;
                        end
                        else
                        begin
                            wr.key_we = 1'b1;
                            wr_addr   = tgt_reg;
                            if (evict_reg)
                            begin
                                valid_next[old_idx_reg] = 1'b0;
                            end
                            else
                            begin
                                count_next = count_reg + CNT_W'(1);
                            end
                            valid_next[tgt_reg] = 1'b1;
                        end
                    end
                    FUNC_DEL:
                    begin
                        if (hit_reg)
                        begin
                            valid_next[slot_reg] = 1'b0;
                            count_next           = count_reg - CNT_W'(1);
                        end
                    end
                    default:
                    begin
                    end
                endcase
                res_next.hit        = hit_reg && (func_reg == FUNC_GET
                                                  || func_reg == FUNC_PUT
                                                  || func_reg == FUNC_DEL);
                res_next.read_value = (func_reg == FUNC_GET && hit_reg)
                                      ? rd_val_ext[OUT_VAL_W-1:0] : '0;
                res_next.evicted    = evict_reg;
                res_next.evicted_key = evict_reg ? old_key_ext[OUT_KEY_W-1:0] : '0;
                res_next.occupancy  = occ_ext[OCC_W-1:0];
                state_next          = ST_DONE;
            end

            ST_DONE:
            begin
                // Hold the result until the output stage takes it
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and registered handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            valid_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
            count_reg <= count_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        key_reg        <= key_next;
        val_reg        <= val_next;
        hit_reg        <= hit_next;
        slot_reg       <= slot_next;
        rank_s_reg     <= rank_s_next;
        rd_val_reg     <= rd_val_next;
        old_found_reg  <= old_found_next;
        old_idx_reg    <= old_idx_next;
        old_rank_reg   <= old_rank_next;
        old_key_reg    <= old_key_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        evict_reg      <= evict_next;
        mode_inc_reg   <= mode_inc_next;
        mode_dec_reg   <= mode_dec_next;
        tgt_en_reg     <= tgt_en_next;
        tgt_reg        <= tgt_next;
        thr_reg        <= thr_next;
        res_reg        <= res_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

endmodule

>>> rtl/lru_key_value_cache_unit.sv
// Top level of the LRU key-value cache: stream ports, capacity register, output stage.
`timescale 1ns / 1ps

// Fully associative key-value cache of ENTRIES slots with least-recently-used
// replacement. Each request on the slave stream is a get, put or delete; each
// produces exactly one result on the master stream. A request walks the whole
// store through one key comparator in a search sweep and, when recency
// changes, walks it again in a rank rewrite sweep, both through the single
// read port of the entry memories; the input is not taken again until the
// result has left the engine. A finished result sits in the output register
// while the next request is already being searched. Capacity (1..ENTRIES, 0
// reads as 1, larger values as ENTRIES) must be written by the user only while
// the block is idle; the block itself does not enforce this.

module lru_key_value_cache_unit
    import lkv_pkg::*;
#(
    parameter int ENTRIES    = DEF_ENTRIES,
    parameter int KEY_BITS   = DEF_KEY_BITS,
    parameter int VALUE_BITS = DEF_VALUE_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // func [1:0], key [65:2], value [97:66], zero fill [103:98]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // hit [0], read_value [32:1], evicted [33], evicted_key [97:34],
    // occupancy [102:98], zero fill [103]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [CAP_W-1:0]      cfg_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready
);

    logic [CAP_W-1:0] cap_reg;
    logic             m_valid_reg;
    lkv_result_t      m_data_reg;

    logic             eng_ready;
    logic             res_valid;
    logic             res_ready;
    lkv_result_t      res;

    // Capacity register
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            cap_reg <= cfg_data;
        end
    end

    lkv_engine #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_start  (s_axis_tvalid && eng_ready),
        .in_func   (s_axis_tdata[FUNC_W-1:0]),
        .in_key    (s_axis_tdata[FUNC_W +: IN_KEY_W]),
        .in_value  (s_axis_tdata[FUNC_W + IN_KEY_W +: IN_VAL_W]),
        .cap       (cap_reg),
        .in_ready  (eng_ready),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign s_axis_tready = eng_ready;

    // Output register: load when empty or being drained
    assign res_ready = !m_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            m_data_reg <= res;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {1'b0, m_data_reg};

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the LRU key-value cache: directed request table, then random phases.

module tb_top;
    import lkv_pkg::*;

    localparam int ENT          = DEF_ENTRIES;
    // Settle wait, in cycles, used before capacity writes and before the verdict
    localparam int REQ_CYCLES   = 2*ENT+6;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 143;
    localparam int POOL_MAX     = 24;
    localparam int HOLD_AT      = 200;
    localparam int HOLD_CYCLES  = 300;
    localparam int SEND_CALM_LO = 700;
    localparam int SEND_CALM_HI = 850;
    localparam int RECV_CALM_LO = 500;
    localparam int RECV_CALM_HI = 650;
    localparam int FILL_W       = IN_DATA_W-FUNC_W-IN_KEY_W-IN_VAL_W;

    // Operation code the block leaves unused
    localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;

    typedef enum logic {ROW_REQ, ROW_CAP} row_kind_t;

    typedef struct {
        row_kind_t            kind;
        logic [FUNC_W-1:0]    op;
        logic [IN_KEY_W-1:0]  key;
        logic [IN_VAL_W-1:0]  val;
        logic [CAP_W-1:0]     cap;
        bit                   typed;
        lkv_result_t          want;
    } stim_row_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [CAP_W-1:0]      cfg_data      = CAP_RESET;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;

    // Shadow copy of the cache contents and recency order
    logic [IN_KEY_W-1:0] shadow_key [ENT];
    logic [IN_VAL_W-1:0] shadow_val [ENT];
    bit                  shadow_live [ENT];
    int unsigned         shadow_age [ENT];
    int unsigned         shadow_count = 0;
    logic [CAP_W-1:0]    shadow_cap   = CAP_RESET;

    lkv_result_t due_results [$];
    int          fail_count   = 0;
    int          sent_count   = 0;
    int          result_count = 0;

    lru_key_value_cache_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_data      (cfg_data),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Make slot s the most recent; the more recent ones age by one
    function automatic void age_promote(int s);
        int unsigned r;
        r = shadow_age[s];
        for (int i = 0; i < ENT; i++)
            if (shadow_live[i] && i != s && shadow_age[i] < r)
                shadow_age[i]++;
        shadow_age[s] = 0;
    endfunction

    // Free slot s; the less recent ones move up by one
    function automatic void slot_remove(int s);
        int unsigned r;
        r = shadow_age[s];
        shadow_live[s] = 1'b0;
        for (int i = 0; i < ENT; i++)
            if (shadow_live[i] && shadow_age[i] > r)
                shadow_age[i]--;
        if (shadow_count > 0)
            shadow_count--;
    endfunction

    // Apply one request to the shadow cache and return its result
    function automatic lkv_result_t lru_access(logic [FUNC_W-1:0] op,
                                               logic [IN_KEY_W-1:0] k,
                                               logic [IN_VAL_W-1:0] v);
        lkv_result_t res;
        int unsigned lim;
        int          s;
        int          lru;
        int          free_slot;
        res = '0;
        lim = shadow_cap;
        if (lim == 0)
            lim = 1;
        if (lim > ENT)
            lim = ENT;
        s = -1;
        for (int i = 0; i < ENT; i++)
            if (s < 0 && shadow_live[i] && shadow_key[i] == k)
                s = i;
        case (op)
            FUNC_GET:
            begin
                if (s >= 0)
                begin
                    res.hit        = 1'b1;
                    res.read_value = shadow_val[s];
                    age_promote(s);
                end
            end
            FUNC_PUT:
            begin
                if (s >= 0)
                begin
                    res.hit       = 1'b1;
                    shadow_val[s] = v;
                    age_promote(s);
                end
                else
                begin
                    // Evict the least recent entry once the capacity is reached
                    if (shadow_count >= lim)
                    begin
                        lru = -1;
                        for (int i = 0; i < ENT; i++)
                            if (shadow_live[i] && (lru < 0 || shadow_age[i] > shadow_age[lru]))
                                lru = i;
                        if (lru >= 0)
                        begin
                            res.evicted     = 1'b1;
                            res.evicted_key = shadow_key[lru];
                            slot_remove(lru);
                        end
                    end
                    free_slot = -1;
                    for (int i = 0; i < ENT; i++)
                        if (free_slot < 0 && !shadow_live[i])
                            free_slot = i;
                    if (free_slot >= 0)
                    begin
                        for (int i = 0; i < ENT; i++)
                            if (shadow_live[i])
                                shadow_age[i]++;
                        shadow_live[free_slot] = 1'b1;
                        shadow_key[free_slot]  = k;
                        shadow_val[free_slot]  = v;
                        shadow_age[free_slot]  = 0;
                        shadow_count++;
                    end
                end
            end
            FUNC_DEL:
            begin
                if (s >= 0)
                begin
                    res.hit = 1'b1;
                    slot_remove(s);
                end
            end
            default: ;
        endcase
        res.occupancy = shadow_count[CAP_W-1:0];
        return res;
    endfunction

    function automatic lkv_result_t mk_res(bit h, logic [OUT_VAL_W-1:0] rd, bit e,
                                           logic [OUT_KEY_W-1:0] ek, logic [OCC_W-1:0] occ);
        lkv_result_t r;
        r.hit         = h;
        r.read_value  = rd;
        r.evicted     = e;
        r.evicted_key = ek;
        r.occupancy   = occ;
        return r;
    endfunction

    function automatic stim_row_t req_row(logic [FUNC_W-1:0] op, logic [IN_KEY_W-1:0] k,
                                          logic [IN_VAL_W-1:0] v, bit typed,
                                          lkv_result_t want);
        stim_row_t row;
        row.kind  = ROW_REQ;
        row.op    = op;
        row.key   = k;
        row.val   = v;
        row.cap   = '0;
        row.typed = typed;
        row.want  = want;
        return row;
    endfunction

    function automatic stim_row_t cap_row(logic [CAP_W-1:0] c);
        stim_row_t row;
        row       = req_row(FUNC_NONE, '0, '0, 1'b0, '0);
        row.kind  = ROW_CAP;
        row.cap   = c;
        return row;
    endfunction

    task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Offer one request, hold it until taken, then record its expected result
    task automatic drive_request(logic [FUNC_W-1:0] op, logic [IN_KEY_W-1:0] k,
                                 logic [IN_VAL_W-1:0] v, bit typed, lkv_result_t want);
        lkv_result_t predicted;
        while (!(sent_count >= SEND_CALM_LO && sent_count < SEND_CALM_HI)
               && $urandom_range(99) < 9)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tdata  <= {{FILL_W{1'b0}}, v, k, op};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predicted = lru_access(op, k, v);
        due_results.push_back(typed ? want : predicted);
        sent_count++;
    endtask

    // Drain the block, let it settle, then write the capacity register
    task automatic set_capacity(logic [CAP_W-1:0] c);
        s_axis_tvalid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (REQ_CYCLES) @(posedge clk);
        cfg_data  <= c;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid  <= 1'b0;
        shadow_cap  = c;
    endtask

    // Result side: check each accepted result, stall at random, hold off once
    initial
    begin
        lkv_result_t got;
        lkv_result_t want;
        int          hold_left;
        bit          hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                got = lkv_result_t'(m_axis_tdata[$bits(lkv_result_t)-1:0]);
                result_count++;
                if (due_results.size() == 0)
                begin
                    $display("%0t: result with nothing expected, expected none, actual %h",
                             $time, m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    want = due_results.pop_front();
                    compare_field("hit", want.hit, got.hit);
                    compare_field("read_value", want.read_value, got.read_value);
                    compare_field("evicted", want.evicted, got.evicted);
                    compare_field("evicted_key", want.evicted_key, got.evicted_key);
                    compare_field("occupancy", want.occupancy, got.occupancy);
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (!hold_done && result_count == HOLD_AT)
            begin
                hold_done     = 1'b1;
                hold_left     = HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= (result_count >= RECV_CALM_LO && result_count < RECV_CALM_HI)
                                 || $urandom_range(99) >= 9;
        end
    end

    // Request side: directed table, then random phases under varied capacities
    initial
    begin
        stim_row_t           rows [$];
        logic [IN_KEY_W-1:0] key_pool [POOL_MAX];
        logic [CAP_W-1:0]    cap_plan [5];
        logic [CAP_W-1:0]    cap_now;
        logic [FUNC_W-1:0]   op;
        logic [IN_KEY_W-1:0] k;
        int                  pool_n;
        int                  pick;
        cap_plan = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd4};

        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty cache, unused code, key and value extremes, hits on each operation
        rows.push_back(req_row(FUNC_GET, '0, '0, 1'b1, mk_res(0, 0, 0, 0, 0)));
        rows.push_back(req_row(FUNC_DEL, '1, '0, 1'b1, mk_res(0, 0, 0, 0, 0)));
        rows.push_back(req_row(FUNC_NONE, '1, '1, 1'b1, mk_res(0, 0, 0, 0, 0)));
        rows.push_back(req_row(FUNC_PUT, '0, '1, 1'b1, mk_res(0, 0, 0, 0, 1)));
        rows.push_back(req_row(FUNC_PUT, '1, '0, 1'b1, mk_res(0, 0, 0, 0, 2)));
        rows.push_back(req_row(FUNC_GET, '0, '0, 1'b1, mk_res(1, '1, 0, 0, 2)));
        rows.push_back(req_row(FUNC_PUT, '0, 32'h1234_5678, 1'b1, mk_res(1, 0, 0, 0, 2)));
        rows.push_back(req_row(FUNC_GET, '1, '1, 1'b1, mk_res(1, 0, 0, 0, 2)));
        rows.push_back(req_row(FUNC_DEL, '0, '0, 1'b1, mk_res(1, 0, 0, 0, 1)));
        rows.push_back(req_row(FUNC_GET, '0, '0, 1'b1, mk_res(0, 0, 0, 0, 1)));
        rows.push_back(req_row(FUNC_NONE, '0, '0, 1'b1, mk_res(0, 0, 0, 0, 1)));
        // Capacity of one, then zero which reads as one
        rows.push_back(cap_row(5'd1));
        rows.push_back(req_row(FUNC_PUT, 64'h5, 32'hA, 1'b1, mk_res(0, 0, 1, '1, 1)));
        rows.push_back(cap_row(5'd0));
        rows.push_back(req_row(FUNC_PUT, 64'h6, 32'hB, 1'b1, mk_res(0, 0, 1, 64'h5, 1)));
        rows.push_back(req_row(FUNC_GET, 64'h6, '0, 1'b1, mk_res(1, 32'hB, 0, 0, 1)));
        // Capacity above the entry count reads as the entry count
        rows.push_back(cap_row(5'd31));
        rows.push_back(req_row(FUNC_PUT, 64'hA5A5_A5A5_A5A5_A5A5, 32'h5A5A_5A5A, 1'b0, '0));
        rows.push_back(req_row(FUNC_PUT, 64'h8000_0000_0000_0000, 32'h8000_0000, 1'b0, '0));
        rows.push_back(req_row(FUNC_PUT, 64'h7FFF_FFFF_FFFF_FFFF, 32'h7FFF_FFFF, 1'b0, '0));
        rows.push_back(req_row(FUNC_GET, 64'h6, '0, 1'b0, '0));
        // Capacity lowered below occupancy: misses evict one each, nothing drops at once
        rows.push_back(cap_row(5'd2));
        rows.push_back(req_row(FUNC_PUT, 64'h1234, 32'h1, 1'b0, '0));
        rows.push_back(req_row(FUNC_PUT, 64'h1235, 32'h2, 1'b0, '0));
        rows.push_back(req_row(FUNC_DEL, 64'h6, '0, 1'b0, '0));
        rows.push_back(req_row(FUNC_PUT, 64'h1235, 32'h3, 1'b0, '0));

        foreach (rows[i])
        begin
            if (rows[i].kind == ROW_CAP)
                set_capacity(rows[i].cap);
            else
                drive_request(rows[i].op, rows[i].key, rows[i].val, rows[i].typed,
                              rows[i].want);
        end

        // Random phases: keys drawn from a pool a little larger than the capacity
        for (int ph = 0; ph < PHASES; ph++)
        begin
            cap_now = (ph < 5) ? cap_plan[ph] : CAP_W'($urandom_range(31));
            set_capacity(cap_now);
            pool_n = (cap_now == 0) ? 1 : (cap_now > ENT) ? ENT : int'(cap_now);
            pool_n = pool_n + $urandom_range(6, 1);
            for (int i = 0; i < POOL_MAX; i++)
                key_pool[i] = {$urandom, $urandom};
            if (ph % 3 == 0)
            begin
                key_pool[0] = '0;
                key_pool[1] = '1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(99);
                op   = (pick < 38) ? FUNC_GET : (pick < 76) ? FUNC_PUT :
                       (pick < 94) ? FUNC_DEL : FUNC_NONE;
                k    = ($urandom_range(9) == 0) ? {$urandom, $urandom}
                                                : key_pool[$urandom_range(pool_n-1)];
                drive_request(op, k, $urandom, 1'b0, '0);
            end
        end

        // Drain, then allow the block to settle before the verdict
        s_axis_tvalid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (2*REQ_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Guard against a hung handshake
    initial
    begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
